[design/sros_pkg.sv]
package sros_pkg;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 10;
  localparam int POS_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_BATCH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NONE     = 2'd2,
    ST_BAD_SPAN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WR, S_CLR, S_DUP_RD, S_DUP_EV,
    S_F1_RD, S_F1_EV, S_F2_RD, S_F2_EV, S_BK_RD, S_BK_EV,
    S_VF_RD, S_VF_EV, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    KS_CURSOR, KS_CUR, KS_HIT
  } ksrc_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;
    logic    wr_reg;
    logic    clr_init;
    logic    clr_step;
    logic    cursor_clr;
    logic    sel_re;
    logic    stop_en;
    logic    dir_bwd;
    logic    k_load;
    ksrc_t   k_src;
    logic    step;
    logic    cap_cur;
    logic    cap_hi;
    logic    cap_lo;
    logic    commit;
    logic    set_st;
    status_t st;
    logic    found;
    logic    out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic ov;
    logic hit;
    logic fail;
    logic k_eq_hi;
    logic dup;
    logic start_bad;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

[design/sros_in_if.sv]
interface sros_in_if;
  import sros_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] region_index;
  logic [POS_W-1:0] region_min;
  logic [POS_W-1:0] region_max;
  logic [IDX_W-1:0] sample_offset;
  logic [POS_W-1:0] cell_start;
  logic [POS_W-1:0] cell_end;
  logic [POS_W-1:0] cell_real_end;

  modport source (output valid, cmd, region_index, region_min, region_max, sample_offset,
                  cell_start, cell_end, cell_real_end, input ready);
  modport sink (input valid, cmd, region_index, region_min, region_max, sample_offset,
                cell_start, cell_end, cell_real_end, output ready);
endinterface

[design/sros_out_if.sv]
interface sros_out_if;
  import sros_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    first_region;
  logic [IDX_W-1:0]    last_region;

  modport source (output valid, status, first_region, last_region, input ready);
  modport sink (input valid, status, first_region, last_region, output ready);
endinterface

[design/sros_ram.sv]
module sros_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sros_dp.sv]
module sros_dp import sros_pkg::*; #(
  parameter int MAX_REGIONS       = 1024,
  parameter int MAX_BATCH_SAMPLES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [IDX_W-1:0]  in_region_index,
  input  logic [POS_W-1:0]  in_region_min,
  input  logic [POS_W-1:0]  in_region_max,
  input  logic [IDX_W-1:0]  in_sample_offset,
  input  logic [POS_W-1:0]  in_cell_start,
  input  logic [POS_W-1:0]  in_cell_end,
  input  logic [POS_W-1:0]  in_cell_real_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [IDX_W-1:0]  out_first_region,
  output logic [IDX_W-1:0]  out_last_region
);

  localparam int RAW = $clog2(MAX_REGIONS);
  localparam int CW  = $clog2(MAX_REGIONS + 1);
  localparam int SAW = (MAX_BATCH_SAMPLES > 1) ? $clog2(MAX_BATCH_SAMPLES) : 1;

  logic [CNT_W-1:0] region_count_r;
  logic [IDX_W-1:0] slot_r, smp_r;
  logic [POS_W-1:0] rmin_r, rmax_r, s_r, e_r, re_r;
  logic [RAW-1:0]   k_r, kp_r, cursor_r, cur_r, hi_r, lo_r;
  logic             p_r;
  logic [SAW-1:0]   clr_r;
  logic             out_valid_r, found_r;
  status_t          res_st_r;

  logic [CW-1:0]    n;
  logic             slot_ok, smp_ok;
  logic [2*POS_W-1:0] reg_rdata;
  logic [POS_W-1:0] smp_rdata, lo_v, hi_v, rng_e;
  logic             ov, lt, at_end, pend_hit, hit;
  logic [RAW-1:0]   hit_idx, k_nxt;
  logic             smp_we;
  logic [SAW-1:0]   smp_waddr;
  logic [POS_W-1:0] smp_wdata;

  assign n = (32'(region_count_r) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(region_count_r);
  assign slot_ok = 32'(slot_r) < MAX_REGIONS;
  assign smp_ok  = 32'(smp_r) < MAX_BATCH_SAMPLES;

  sros_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_REGIONS)) u_region_ram (
    .clk   (clk),
    .we    (ctl.wr_reg && slot_ok),
    .waddr (RAW'(slot_r)),
    .wdata ({rmax_r, rmin_r}),
    .raddr (k_r),
    .rdata (reg_rdata)
  );

  assign smp_we    = ctl.clr_step || (ctl.commit && smp_ok);
  assign smp_waddr = ctl.clr_step ? clr_r : SAW'(smp_r);
  assign smp_wdata = ctl.clr_step ? '1 : re_r;

  sros_ram #(.WIDTH(POS_W), .DEPTH(MAX_BATCH_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (smp_wdata),
    .raddr (SAW'(smp_r)),
    .rdata (smp_rdata)
  );

  assign lo_v  = reg_rdata[POS_W-1:0];
  assign hi_v  = reg_rdata[2*POS_W-1:POS_W];
  assign rng_e = ctl.sel_re ? re_r : e_r;
  assign ov    = (s_r <= hi_v) && (rng_e >= lo_v);
  assign lt    = e_r < lo_v;
  assign at_end = ctl.dir_bwd ? (k_r == '0) : ((CW'(k_r) + CW'(1)) == n);
  // a pending overlap at the previous index closes when this one misses
  assign pend_hit = p_r && !ov;
  assign hit      = pend_hit || (ov && at_end);
  assign hit_idx  = pend_hit ? kp_r : k_r;

  always_comb begin
    sts.ov        = ov;
    sts.hit       = hit;
    sts.fail      = !hit && ((ctl.stop_en && lt) || at_end);
    sts.k_eq_hi   = k_r == hi_r;
    sts.dup       = smp_ok && (smp_rdata == re_r);
    sts.start_bad = CW'(cursor_r) >= n;
    sts.clr_last  = clr_r == SAW'(MAX_BATCH_SAMPLES - 1);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    case (ctl.k_src)
      KS_CURSOR: k_nxt = cursor_r;
      KS_CUR:    k_nxt = cur_r;
      KS_HIT:    k_nxt = hit_idx;
      default:   k_nxt = cursor_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
      cursor_r       <= '0;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        region_count_r <= cfg_wdata;
      end
      if (ctl.clr_init) begin
        clr_r <= '0;
      end else if (ctl.clr_step) begin
        clr_r <= clr_r + SAW'(1);
      end
      if (ctl.cursor_clr) begin
        cursor_r <= '0;
      end else if (ctl.commit) begin
        cursor_r <= cur_r;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      slot_r <= in_region_index;
      rmin_r <= in_region_min;
      rmax_r <= in_region_max;
      smp_r  <= in_sample_offset;
      s_r    <= in_cell_start;
      e_r    <= in_cell_end;
      re_r   <= in_cell_real_end;
    end
    if (ctl.k_load) begin
      k_r <= k_nxt;
      p_r <= 1'b0;
    end else if (ctl.step) begin
      kp_r <= k_r;
      k_r  <= ctl.dir_bwd ? k_r - RAW'(1) : k_r + RAW'(1);
      p_r  <= ov;
    end
    if (ctl.cap_cur) cur_r <= hit_idx;
    if (ctl.cap_hi)  hi_r  <= hit_idx;
    if (ctl.cap_lo)  lo_r  <= hit_idx;
    if (ctl.set_st) begin
      res_st_r <= ctl.st;
      found_r  <= ctl.found;
    end
    if (ctl.out_load) begin
      out_status       <= res_st_r;
      out_first_region <= found_r ? IDX_W'(lo_r) : '0;
      out_last_region  <= found_r ? IDX_W'(hi_r) : '0;
    end
  end

  assign out_valid = out_valid_r;

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_load && found_r) |-> lo_r <= hi_r)
    else $error("found run has first after last");

  a_fwd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && !ctl.dir_bwd) |-> CW'(k_r) < n)
    else $error("forward scan beyond region count");

  a_commit_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (CW'(cur_r) < n && lo_r <= cur_r && cur_r <= hi_r))
    else $error("committed cursor outside found run");

endmodule

[design/sros_ctrl.sv]
module sros_ctrl import sros_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  sts_t             sts,
  output ctl_t             ctl
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_LOAD:  state_nxt = S_WR;
            CMD_QUERY: state_nxt = S_DUP_RD;
            CMD_BATCH: state_nxt = S_CLR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_WR:     state_nxt = S_DONE;
      S_CLR:    if (sts.clr_last) state_nxt = S_DONE;
      S_DUP_RD: state_nxt = S_DUP_EV;
      S_DUP_EV: state_nxt = (sts.dup || sts.start_bad) ? S_DONE : S_F1_RD;
      S_F1_RD:  state_nxt = S_F1_EV;
      S_F1_EV: begin
        if (sts.hit) state_nxt = S_F2_RD;
        else if (sts.fail) state_nxt = S_DONE;
        else state_nxt = S_F1_RD;
      end
      S_F2_RD:  state_nxt = S_F2_EV;
      S_F2_EV:  state_nxt = (sts.hit || sts.fail) ? S_BK_RD : S_F2_RD;
      S_BK_RD:  state_nxt = S_BK_EV;
      S_BK_EV: begin
        if (sts.hit) state_nxt = S_VF_RD;
        else if (sts.fail) state_nxt = S_DONE;
        else state_nxt = S_BK_RD;
      end
      S_VF_RD:  state_nxt = S_VF_EV;
      S_VF_EV:  state_nxt = (!sts.ov || sts.k_eq_hi) ? S_DONE : S_VF_RD;
      S_DONE:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.k_src = KS_CURSOR;
    ctl.st    = ST_OK;
    case (state_r)
      S_INIT: ctl.clr_step = 1'b1;
      S_IDLE: begin
        ctl.latch    = accept;
        ctl.clr_init = accept;
        ctl.set_st   = accept;
      end
      S_CLR: begin
        ctl.clr_step   = 1'b1;
        ctl.cursor_clr = sts.clr_last;
      end
      S_WR: ctl.wr_reg = 1'b1;
      S_DUP_EV: begin
        ctl.k_load = 1'b1;
        ctl.k_src  = KS_CURSOR;
        ctl.set_st = sts.dup || sts.start_bad;
        ctl.st     = sts.dup ? ST_DUP : ST_NONE;
      end
      S_F1_EV: begin
        ctl.stop_en = 1'b1;
        ctl.k_load  = sts.hit;
        ctl.k_src   = KS_HIT;
        ctl.cap_cur = sts.hit;
        ctl.cap_hi  = sts.hit;
        ctl.step    = !sts.hit && !sts.fail;
        ctl.set_st  = !sts.hit && sts.fail;
        ctl.st      = ST_NONE;
      end
      S_F2_EV: begin
        ctl.sel_re = 1'b1;
        ctl.cap_hi = sts.hit;
        ctl.k_load = sts.hit || sts.fail;
        ctl.k_src  = KS_CUR;
        ctl.step   = !sts.hit && !sts.fail;
      end
      S_BK_RD: begin
        ctl.sel_re  = 1'b1;
        ctl.dir_bwd = 1'b1;
      end
      S_BK_EV: begin
        ctl.sel_re  = 1'b1;
        ctl.dir_bwd = 1'b1;
        ctl.cap_lo  = sts.hit;
        ctl.k_load  = sts.hit;
        ctl.k_src   = KS_HIT;
        ctl.step    = !sts.hit && !sts.fail;
        ctl.set_st  = !sts.hit && sts.fail;
        ctl.st      = ST_BAD_SPAN;
      end
      S_VF_EV: begin
        ctl.sel_re = 1'b1;
        ctl.step   = sts.ov && !sts.k_eq_hi;
        ctl.commit = sts.ov && sts.k_eq_hi;
        ctl.set_st = !sts.ov || sts.k_eq_hi;
        ctl.st     = sts.ov ? ST_OK : ST_BAD_SPAN;
        ctl.found  = sts.ov;
      end
      S_DONE: ctl.out_load = sts.out_free;
      default: ;
    endcase
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transaction taken before the first finished");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> state_r == S_DONE)
    else $error("result dropped while output busy");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> state_r == S_DONE)
    else $error("commit without result");

endmodule

[design/sorted_region_overlap_search_top.sv]
// A new batch sweeps the sample end store and clears the cursor. A query stops after
// its duplicate check on a duplicate or empty start, else reads region by region over
// the forward, second forward, backward and verify passes (one region table read port).
// One transaction in flight; the next is taken as soon as the result is registered.
// Reset (synchronous, rst_n low) clears cursor and region count, then sweeps the
// sample end store to all ones before accepting input.
module sorted_region_overlap_search_top import sros_pkg::*; #(
  parameter int MAX_REGIONS       = 1024,
  parameter int MAX_BATCH_SAMPLES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  sros_in_if.sink          in_ch,
  sros_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  ctl_t ctl;
  sts_t sts;

  sros_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_ch.cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  sros_dp #(
    .MAX_REGIONS       (MAX_REGIONS),
    .MAX_BATCH_SAMPLES (MAX_BATCH_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_region_index  (in_ch.region_index),
    .in_region_min    (in_ch.region_min),
    .in_region_max    (in_ch.region_max),
    .in_sample_offset (in_ch.sample_offset),
    .in_cell_start    (in_ch.cell_start),
    .in_cell_end      (in_ch.cell_end),
    .in_cell_real_end (in_ch.cell_real_end),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_first_region (out_ch.first_region),
    .out_last_region  (out_ch.last_region)
  );

endmodule

[tb/tb.sv]
module tb;
  import sros_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  idx;
    logic [31:0] rmin;
    logic [31:0] rmax;
    logic [9:0]  smp;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] re;
  } cell_t;

  typedef struct {
    status_t    st;
    logic [9:0] first;
    logic [9:0] last;
  } span_t;

  localparam int NREG  = 1024;
  localparam int NSMP  = 1024;
  localparam int NLONG = 256;
  localparam int WDOG  = 60000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  sros_in_if  in_ch();
  sros_out_if out_ch();

  sorted_region_overlap_search_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // shadow copy of the block state
  logic [31:0] tbl_lo[NREG];
  logic [31:0] tbl_hi[NREG];
  logic [31:0] smp_end[NSMP];
  int          cursor;
  int          region_cnt;

  span_t spans_due[$];
  int    errors = 0;
  int    out_stall = 0;
  bit    no_idle = 0;
  int    quiet_cyc = 0;

  task report(string what, int got, int want);
    errors++;
    $display("mismatch: %s got %0d want %0d", what, got, want);
  endtask

  function automatic bit hits(int i, logic [31:0] s, logic [31:0] e);
    return s <= tbl_hi[i] && e >= tbl_lo[i];
  endfunction

  function automatic bit scan_up(int from, int n, logic [31:0] s, logic [31:0] e,
                                 bit stop, output int hit);
    bit here;
    hit = 0;
    for (int i = from; i < n; i++) begin
      if (stop && e < tbl_lo[i]) return 0;
      here = hits(i, s, e);
      if (i + 1 < n) begin
        if (here && !hits(i + 1, s, e)) begin
          hit = i;
          return 1;
        end
      end else if (here) begin
        hit = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit scan_down(int from, logic [31:0] s, logic [31:0] e,
                                   output int hit);
    bit here;
    hit = 0;
    for (int i = from; i >= 0; i--) begin
      here = hits(i, s, e);
      if (i > 0) begin
        if (here && !hits(i - 1, s, e)) begin
          hit = i;
          return 1;
        end
      end else if (here) begin
        hit = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic span_t overlap_search(cell_t c);
    span_t r;
    int n, cur, hi, lo, tmp;
    bit ok;
    r.st = ST_OK;
    r.first = '0;
    r.last = '0;
    n = region_cnt > NREG ? NREG : region_cnt;
    case (c.cmd)
      CMD_LOAD: begin
        tbl_lo[c.idx] = c.rmin;
        tbl_hi[c.idx] = c.rmax;
      end
      CMD_BATCH: begin
        cursor = 0;
        foreach (smp_end[k]) smp_end[k] = '1;
      end
      CMD_QUERY: begin
        if (c.re == smp_end[c.smp]) r.st = ST_DUP;
        else if (!scan_up(cursor, n, c.s, c.e, 1, cur)) r.st = ST_NONE;
        else begin
          hi = cur;
          if (scan_up(cur, n, c.s, c.re, 0, tmp)) hi = tmp;
          ok = scan_down(cur, c.s, c.re, lo);
          if (ok)
            for (int j = lo; j <= hi; j++)
              if (!hits(j, c.s, c.re)) ok = 0;
          if (!ok) r.st = ST_BAD_SPAN;
          else begin
            r.first = 10'(lo);
            r.last = 10'(hi);
            cursor = cur;
            smp_end[c.smp] = c.re;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // inputs change on the falling edge; each call starts and ends there
  task send_cell(cell_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.cmd = c.cmd;
    in_ch.region_index = c.idx;
    in_ch.region_min = c.rmin;
    in_ch.region_max = c.rmax;
    in_ch.sample_offset = c.smp;
    in_ch.cell_start = c.s;
    in_ch.cell_end = c.e;
    in_ch.cell_real_end = c.re;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    spans_due.insert(spans_due.size(), overlap_search(c));
    @(negedge clk);
  endtask

  function automatic cell_t load_cell(int idx, logic [31:0] lo, logic [31:0] hi);
    cell_t c;
    c = '{CMD_LOAD, 10'(idx), lo, hi, 10'($urandom), $urandom, $urandom, $urandom};
    return c;
  endfunction

  function automatic cell_t query_cell(int smp, logic [31:0] s, logic [31:0] e,
                                       logic [31:0] re);
    cell_t c;
    c = '{CMD_QUERY, 10'($urandom), $urandom, $urandom, 10'(smp), s, e, re};
    return c;
  endfunction

  function automatic cell_t op_cell(cmd_t op);
    cell_t c;
    c = '{op, 10'($urandom), $urandom, $urandom, 10'($urandom), $urandom, $urandom,
          $urandom};
    return c;
  endfunction

  task drain;
    in_ch.valid = 0;
    while (spans_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task set_count(int v);
    drain();
    cfg_wdata = CNT_W'(v);
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    region_cnt = v;
  endtask

  // sorted-by-end table in slots 0..n-1 around base
  task load_table(int n, longint base, int step, int width);
    longint hi, lo;
    hi = base;
    for (int k = 0; k < n; k++) begin
      hi = hi + $urandom_range(0, step);
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      lo = hi - $urandom_range(0, width);
      if (lo < 0) lo = 0;
      if ($urandom_range(0, 15) == 0) lo = hi + 1 > 64'hFFFF_FFFF ? hi : hi + 1;
      send_cell(load_cell(k, lo[31:0], hi[31:0]));
    end
  endtask

  task test_empty_and_ops;
    set_count(0);
    send_cell(query_cell(0, 0, 32'hFFFF_FFFF, 5));
    send_cell(op_cell(CMD_NOP));
    send_cell(op_cell(CMD_BATCH));
    send_cell(load_cell(1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task test_directed;
    send_cell(load_cell(0, 5, 10));
    send_cell(load_cell(1, 50, 60));
    send_cell(load_cell(2, 55, 100));
    send_cell(load_cell(3, 0, 200));
    send_cell(load_cell(4, 300, 400));
    send_cell(load_cell(5, 32'hFFFF_FF00, 32'hFFFF_FFFF));
    set_count(6);
    send_cell(op_cell(CMD_BATCH));
    send_cell(query_cell(0, 8, 9, 4));            // backward scan fails
    send_cell(query_cell(0, 8, 9, 70));
    send_cell(query_cell(0, 8, 9, 70));           // duplicate
    send_cell(query_cell(1023, 150, 160, 350));
    send_cell(query_cell(1023, 150, 160, 32'hFFFF_FFFE));
    send_cell(query_cell(2, 210, 250, 260));      // no overlap
    send_cell(query_cell(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_cell(query_cell(4, 0, 0, 0));            // behind the cursor
    set_count(2);                                 // cursor past table
    send_cell(query_cell(5, 0, 32'hFFFF_FFFF, 7));
  endtask

  task test_random_batches(int phases);
    int n, nq, smp;
    longint base, s, e, re;
    for (int p = 0; p < phases; p++) begin
      no_idle = (p % 7 == 3);
      n = $urandom_range(1, 16);
      base = ($urandom_range(0, 5) == 0) ? 64'hFFFF_FF00 : $urandom_range(0, 5000);
      load_table(n, base, 12, 25);
      if ($urandom_range(0, 3) == 0) begin
        set_count($urandom_range(0, n));          // stale cursor kept
      end else begin
        set_count(n);
        send_cell(op_cell(CMD_BATCH));
      end
      nq = $urandom_range(15, 30);
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(0, 9))
          0: send_cell(op_cell(cmd_t'($urandom_range(0, 3))));
          1: send_cell(query_cell($urandom, $urandom, $urandom, $urandom));
          2: send_cell(load_cell($urandom_range(n, 1023), $urandom, $urandom));
          default: begin
            smp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 3);
            s = base + $urandom_range(0, 12 * n + 20) - 10;
            if (s < 0) s = 0;
            e = s + $urandom_range(0, 25);
            re = ($urandom_range(0, 4) == 0) ? s - $urandom_range(0, 10)
                                             : e + $urandom_range(0, 20);
            if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
            if (re > 64'hFFFF_FFFF) re = 64'hFFFF_FFFF;
            if (re < 0) re = 0;
            if ($urandom_range(0, 4) == 0 && smp_end[smp] != '1) re = smp_end[smp];
            send_cell(query_cell(smp, s[31:0], e[31:0], re[31:0]));
          end
        endcase
      end
    end
    no_idle = 0;
  endtask

  // long table; every scan stays inside the loaded slots
  task test_long_table;
    for (int k = 0; k < NLONG; k++)
      send_cell(load_cell(k, 32'(k * 4), 32'(k * 4 + 6)));
    set_count(NLONG);
    send_cell(op_cell(CMD_BATCH));
    send_cell(query_cell(0, 1010, 1012, 1014));
    send_cell(query_cell(1, 1018, 1020, 1030));   // run ends at the last region
    send_cell(query_cell(2, 10, 11, 20));
    set_count(2047);
    send_cell(op_cell(CMD_BATCH));
    send_cell(query_cell(2, 600, 601, 700));
    send_cell(query_cell(3, 0, 0, 30));
  endtask

  always @(negedge clk) begin
    if (out_stall > 0 && !no_idle) begin
      out_ch.ready = 0;
      out_stall--;
    end else begin
      out_ch.ready = 1;
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (out_ch.valid && out_ch.ready) begin
      out_stall = $urandom_range(0, 5);
      if (spans_due.size() == 0) begin
        report("unexpected transaction status", out_ch.status, -1);
      end else begin
        want = spans_due.pop_front();
        if (out_ch.status !== want.st) report("status", out_ch.status, want.st);
        if (out_ch.first_region !== want.first)
          report("first_region", out_ch.first_region, want.first);
        if (out_ch.last_region !== want.last)
          report("last_region", out_ch.last_region, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cyc = 0;
    else quiet_cyc++;
    if (quiet_cyc >= WDOG) begin
      $display("FAIL sorted_region_overlap_search_top");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = CMD_NOP;
    in_ch.region_index = '0;
    in_ch.region_min = '0;
    in_ch.region_max = '0;
    in_ch.sample_offset = '0;
    in_ch.cell_start = '0;
    in_ch.cell_end = '0;
    in_ch.cell_real_end = '0;
    out_ch.ready = 0;
    foreach (tbl_lo[k]) begin
      tbl_lo[k] = '0;
      tbl_hi[k] = '0;
    end
    foreach (smp_end[k]) smp_end[k] = '1;
    cursor = 0;
    region_cnt = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // sample end store is swept after reset
    repeat (NSMP + 20) @(negedge clk);
    test_empty_and_ops();
    test_directed();
    test_random_batches(21);
    test_long_table();
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && spans_due.size() == 0)
      $display("PASS sorted_region_overlap_search_top");
    else
      $display("FAIL sorted_region_overlap_search_top");
    $finish;
  end

endmodule
